### hw/rtl/arpc_pkg.sv
// arpc_pkg: shared types and constants of the arp cache table
// used by arpc_ctrl, arpc_dp and arp_cache_table; no dependencies
package arpc_pkg;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int AGE_W      = 8;
  localparam int FUNC_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TDATA_W    = 80;
  localparam int TUSER_O_W  = 2;

  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd5;
  localparam logic [AGE_W-1:0] AGE_SAT       = 8'hFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LOCAL_IP    = 2'd0,
    CFG_SUBNET_MASK = 2'd1,
    CFG_GATEWAY_IP  = 2'd2,
    CFG_MAX_AGE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PRIME  = 2'd1,
    ST_SCAN   = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_issue;
    logic process;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic last_entry;
    logic stall;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] age;
  } entry_t;

endpackage

### hw/rtl/arpc_ctrl.sv
// arpc_ctrl: sequencing state machine of the arp cache table
// depends on arpc_pkg; drives the datapath through arpc_pkg::cmd_t
module arpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  arpc_pkg::status_t  st,
  output arpc_pkg::cmd_t     cmd
);

  arpc_pkg::state_t state;
  arpc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      arpc_pkg::ST_IDLE: begin
        if (in_valid) state_next = arpc_pkg::ST_PRIME;
      end
      arpc_pkg::ST_PRIME: begin
        state_next = arpc_pkg::ST_SCAN;
      end
      arpc_pkg::ST_SCAN: begin
        if (!st.stall && (st.hit || st.last_entry)) state_next = arpc_pkg::ST_FINISH;
      end
      arpc_pkg::ST_FINISH: begin
        if (st.out_free) state_next = arpc_pkg::ST_IDLE;
      end
      default: begin
        state_next = arpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      arpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      arpc_pkg::ST_PRIME: begin
        cmd.rd_issue = 1'b1;
      end
      arpc_pkg::ST_SCAN: begin
        cmd.process  = 1'b1;
        cmd.rd_issue = !st.stall && !st.hit && !st.last_entry;
      end
      arpc_pkg::ST_FINISH: begin
        cmd.finish = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/arpc_dp.sv
// arpc_dp: entry store, scan pipeline, config registers and result register
// depends on arpc_pkg; commanded by arpc_ctrl
module arpc_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  arpc_pkg::cmd_t                    cmd,
  output arpc_pkg::status_t                 st,
  input  logic                              cfg_we,
  input  logic [arpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [arpc_pkg::FUNC_W-1:0]       in_func,
  input  logic [arpc_pkg::IP_W-1:0]         in_ip,
  input  logic [arpc_pkg::MAC_W-1:0]        in_mac,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_ok,
  output logic [arpc_pkg::MAC_W-1:0]        out_mac,
  output logic                              out_rv,
  output logic [arpc_pkg::IP_W-1:0]         out_rip,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(ENTRIES);

  // config registers
  logic [arpc_pkg::IP_W-1:0]  local_ip;
  logic [arpc_pkg::IP_W-1:0]  subnet_mask;
  logic [arpc_pkg::IP_W-1:0]  gateway_ip;
  logic [arpc_pkg::AGE_W-1:0] max_age;

  // current operation
  arpc_pkg::func_t            op_func;
  logic [arpc_pkg::IP_W-1:0]  op_ip;
  logic [arpc_pkg::MAC_W-1:0] op_mac;
  logic [arpc_pkg::IP_W-1:0]  target;

  // store
  arpc_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  logic [ENTRIES-1:0] valid;

  // scan pipeline
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  pidx;
  arpc_pkg::entry_t  rd_entry;
  logic              rd_written;

  // per-operation working registers
  logic                       res_hit;
  logic [arpc_pkg::MAC_W-1:0] res_mac;
  logic                       has_free;
  logic [IDX_W-1:0]           free_slot;
  logic [IDX_W-1:0]           old_slot;
  logic [arpc_pkg::AGE_W-1:0] old_age;
  logic                       pend_valid;
  logic [arpc_pkg::IP_W-1:0]  pend_ip;

  // combinational
  logic [arpc_pkg::IP_W-1:0]  e_ip;
  logic [arpc_pkg::MAC_W-1:0] e_mac;
  logic [arpc_pkg::AGE_W-1:0] e_age;
  logic [arpc_pkg::AGE_W-1:0] age_inc;
  logic                       cur_valid;
  logic                       keep;
  logic                       hit;
  logic                       is_tick;
  logic                       stall;
  logic                       act;
  logic                       push;
  logic                       out_free;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_waddr;
  arpc_pkg::entry_t           mem_wdata;
  logic [IDX_W-1:0]           wr_slot;

  function automatic logic [arpc_pkg::IP_W-1:0] route(
    input logic [arpc_pkg::IP_W-1:0] a,
    input logic [arpc_pkg::IP_W-1:0] own,
    input logic [arpc_pkg::IP_W-1:0] mask,
    input logic [arpc_pkg::IP_W-1:0] gw
  );
    route = (((a ^ own) & mask) == '0) ? a : gw;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= '0;
      subnet_mask <= '0;
      gateway_ip  <= '0;
      max_age     <= arpc_pkg::MAX_AGE_RESET;
    end else if (cfg_we) begin
      case (arpc_pkg::cfg_idx_t'(cfg_addr))
        arpc_pkg::CFG_LOCAL_IP:    local_ip    <= cfg_wdata;
        arpc_pkg::CFG_SUBNET_MASK: subnet_mask <= cfg_wdata;
        arpc_pkg::CFG_GATEWAY_IP:  gateway_ip  <= cfg_wdata;
        arpc_pkg::CFG_MAX_AGE:     max_age     <= cfg_wdata[arpc_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  // entry being looked at; never-written slots read as zero
  always_comb begin
    e_ip      = rd_written ? rd_entry.ip  : '0;
    e_mac     = rd_written ? rd_entry.mac : '0;
    e_age     = rd_written ? rd_entry.age : '0;
    cur_valid = valid[pidx];
    age_inc   = (e_age == arpc_pkg::AGE_SAT) ? e_age : e_age + arpc_pkg::AGE_W'(1);
    keep      = cur_valid && (age_inc <= max_age);
    is_tick   = (op_func == arpc_pkg::FUNC_TICK);
    case (op_func)
      arpc_pkg::FUNC_READ:   hit = cur_valid && (e_ip == target);
      arpc_pkg::FUNC_WRITE:  hit = cur_valid && (e_ip == op_ip);
      arpc_pkg::FUNC_DELETE: hit = (e_ip == target);
      default:               hit = 1'b0;
    endcase
    out_free = !out_valid || out_ready;
    stall    = cmd.process && is_tick && keep && pend_valid && !out_free;
    act      = cmd.process && !stall;
    push     = act && is_tick && keep && pend_valid;
    wr_slot  = has_free ? free_slot : old_slot;
  end

  always_comb begin
    st.hit        = hit;
    st.last_entry = (pidx == IDX_W'(ENTRIES - 1));
    st.stall      = stall;
    st.out_free   = out_free;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pidx;
    mem_wdata = '{ip: op_ip, mac: op_mac, age: '0};
    if (act && (op_func == arpc_pkg::FUNC_WRITE) && hit) begin
      mem_we = 1'b1;
    end else if (act && is_tick && cur_valid) begin
      mem_we    = 1'b1;
      mem_wdata = '{ip: e_ip, mac: e_mac, age: age_inc};
    end else if (cmd.finish && (op_func == arpc_pkg::FUNC_WRITE) && !res_hit) begin
      mem_we    = 1'b1;
      mem_waddr = wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_issue) rd_entry <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      valid      <= '0;
      rd_written <= 1'b0;
    end else begin
      if (mem_we) written[mem_waddr] <= 1'b1;
      if (cmd.rd_issue) rd_written <= written[idx];
      if (act && (op_func == arpc_pkg::FUNC_DELETE) && hit) valid[pidx] <= 1'b0;
      if (act && is_tick && cur_valid && !keep) valid[pidx] <= 1'b0;
      if (cmd.finish && (op_func == arpc_pkg::FUNC_WRITE) && !res_hit) valid[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= arpc_pkg::func_t'(in_func);
      op_ip   <= in_ip;
      op_mac  <= in_mac;
      target  <= route(in_ip, local_ip, subnet_mask, gateway_ip);
      idx     <= '0;
      pidx    <= '0;
    end else if (cmd.rd_issue) begin
      pidx <= idx;
      idx  <= idx + IDX_W'(1);
    end
  end

  // hit capture and victim tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_hit   <= 1'b0;
      res_mac   <= '0;
      has_free  <= 1'b0;
      free_slot <= '0;
      old_slot  <= '0;
      old_age   <= '0;
      pend_ip   <= '0;
    end else if (act) begin
      if (hit) begin
        res_hit <= 1'b1;
        res_mac <= e_mac;
      end
      if (op_func == arpc_pkg::FUNC_WRITE) begin
        if (pidx == '0) begin
          old_age  <= e_age;
          old_slot <= '0;
        end else if (cur_valid && (e_age > old_age)) begin
          old_age  <= e_age;
          old_slot <= pidx;
        end
        if (!cur_valid) begin
          has_free  <= 1'b1;
          free_slot <= pidx;
        end
      end
      if (is_tick && keep) pend_ip <= route(e_ip, local_ip, subnet_mask, gateway_ip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
    end else if (act && is_tick && keep) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_ok   <= 1'b0;
      out_mac  <= '0;
      out_rv   <= 1'b1;
      out_rip  <= pend_ip;
      out_last <= 1'b0;
    end else if (cmd.finish) begin
      out_mac  <= '0;
      out_rv   <= 1'b0;
      out_rip  <= '0;
      out_last <= 1'b1;
      case (op_func)
        arpc_pkg::FUNC_READ: begin
          out_ok  <= res_hit;
          out_mac <= res_mac;
        end
        arpc_pkg::FUNC_WRITE: begin
          out_ok <= 1'b1;
        end
        arpc_pkg::FUNC_DELETE: begin
          out_ok <= res_hit;
        end
        arpc_pkg::FUNC_TICK: begin
          out_ok  <= 1'b0;
          out_rv  <= pend_valid;
          out_rip <= pend_valid ? pend_ip : '0;
        end
        default: begin
          out_ok <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/arp_cache_table.sv
// arp_cache_table: ip to mac cache with aging and refresh requests, top level
// depends on arpc_pkg, arpc_ctrl and arpc_dp
//
// The table holds ENTRIES slots of ip, mac, valid and age. Every operation is
// one input transaction (func in s_axis_tuser) and is handled by a linear scan
// of the slots: one slot per cycle through an entry memory with one registered
// read port and one write port. Read, write and delete give exactly one result transaction
// with tlast set; a refresh tick gives one request transaction per kept slot
// in slot order, the final one marked with tlast, or a single all-zero
// transaction with tlast when nothing is kept. Read and delete map an
// off-subnet address to the gateway first; write stores the address as given.
// An operation that scans the whole table passes through accept, first read,
// one compare per slot and result; a read, write or delete that hits ends
// the scan early, and a tick also waits whenever its result register
// is still full and a further request is found. A new input is taken only
// after the previous operation has placed its last result in the output
// register, so a waiting result does not stop the next operation from
// starting. The store is empty right after reset with no clearing pass. The user
// writes config via cfg_we/cfg_addr/cfg_wdata only while idle; the block does not check.
module arp_cache_table #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input transactions
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [arpc_pkg::TDATA_W-1:0]      s_axis_tdata,  // ip[31:0], mac[79:32]
  input  logic [arpc_pkg::FUNC_W-1:0]       s_axis_tuser,  // func[1:0]
  // result transactions
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [arpc_pkg::TDATA_W-1:0]      m_axis_tdata,  // mac_out[47:0], request_ip[79:48]
  output logic [arpc_pkg::TUSER_O_W-1:0]    m_axis_tuser,  // ok[0], request_valid[1]
  output logic                              m_axis_tlast,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [arpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  arpc_pkg::cmd_t    cmd;
  arpc_pkg::status_t st;

  logic                       out_ok;
  logic [arpc_pkg::MAC_W-1:0] out_mac;
  logic                       out_rv;
  logic [arpc_pkg::IP_W-1:0]  out_rip;

  // sequencing
  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // store, scan and result register
  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_func   (s_axis_tuser),
    .in_ip     (s_axis_tdata[arpc_pkg::IP_W-1:0]),
    .in_mac    (s_axis_tdata[arpc_pkg::TDATA_W-1:arpc_pkg::IP_W]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_ok    (out_ok),
    .out_mac   (out_mac),
    .out_rv    (out_rv),
    .out_rip   (out_rip),
    .out_last  (m_axis_tlast)
  );

  // result packing
  assign m_axis_tdata = {out_rip, out_mac};
  assign m_axis_tuser = {out_rv, out_ok};

  // a refresh request never reports a hit
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("request result carries ok");

  // only refresh requests can be followed by more results of the same input
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[1])
    else $error("non-final result that is not a request");

  // a result without ok carries no mac
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[arpc_pkg::MAC_W-1:0] == '0))
    else $error("mac on a miss or request");

  // one operation at a time: no input is taken right after one was accepted
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

endmodule
